/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising edge, ignored while reset is asserted.
`define QVR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property sampled on the rising edge, also checked during reset.
`define QVR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* hdl/qvr_pkg.sv */
package qvr_pkg;

    // Quaternion fraction bits (Q2.14 by default).
    localparam int QUAT_FRAC_BITS = 14;

    localparam int COMP_W  = 16;     // vector and quaternion components
    localparam int IQ_W    = 33;     // stage-one quaternion parts, exact
    localparam int PROD_W  = 49;     // stage-two products, exact
    localparam int HALF_W  = 50;     // difference of two stage-two products
    localparam int RND_W   = 64;     // rounding adder, covers shifts up to 60
    localparam int RND_SH  = 2 * QUAT_FRAC_BITS;

    localparam logic signed [RND_W-1:0] RND_HALF =
        RND_W'(64'sd1 <<< (RND_SH - 1));
    localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'(64'sd32767);
    localparam logic signed [RND_W-1:0] SAT_MIN = -RND_W'(64'sd32768);

    typedef struct packed {
        logic signed [COMP_W-1:0] z;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] x;
    } t_vec;

    typedef struct packed {
        logic signed [COMP_W-1:0] z;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] w;
    } t_quat;

    typedef struct packed {
        logic signed [IQ_W-1:0] w;
        logic signed [IQ_W-1:0] z;
        logic signed [IQ_W-1:0] y;
        logic signed [IQ_W-1:0] x;
    } t_iquat;

    // Each output component is hN0 + hN1, still at scale 2^(2*frac).
    typedef struct packed {
        logic signed [HALF_W-1:0] z1;
        logic signed [HALF_W-1:0] z0;
        logic signed [HALF_W-1:0] y1;
        logic signed [HALF_W-1:0] y0;
        logic signed [HALF_W-1:0] x1;
        logic signed [HALF_W-1:0] x0;
    } t_halves;

    // Pipeline control shared by the stage modules.
    typedef struct packed {
        logic en;      // whole pipeline advances
        logic valid;   // beat entering the stage
    } t_pipe_ctl;

endpackage

/* hdl/qvr_stage_a.sv */
// q * v: twelve 16x16 products, then the four exact sums.
module qvr_stage_a
    import qvr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  t_vec      i_vec,
    input  t_quat     i_quat,
    output logic      o_valid,
    output t_iquat    o_iq,
    output t_quat     o_quat
);

    logic signed [2*COMP_W-1:0] n_prod [12];
    logic signed [2*COMP_W-1:0] r_prod [12];
    t_quat                      r_quat1;
    t_quat                      r_quat2;
    t_iquat                     n_iq;
    t_iquat                     r_iq;
    logic                       r_v1;
    logic                       r_v2;

    always_comb begin
        n_prod[0]  = i_quat.w * i_vec.x;
        n_prod[1]  = i_quat.y * i_vec.z;
        n_prod[2]  = i_quat.z * i_vec.y;
        n_prod[3]  = i_quat.w * i_vec.y;
        n_prod[4]  = i_quat.z * i_vec.x;
        n_prod[5]  = i_quat.x * i_vec.z;
        n_prod[6]  = i_quat.w * i_vec.z;
        n_prod[7]  = i_quat.x * i_vec.y;
        n_prod[8]  = i_quat.y * i_vec.x;
        n_prod[9]  = i_quat.x * i_vec.x;
        n_prod[10] = i_quat.y * i_vec.y;
        n_prod[11] = i_quat.z * i_vec.z;
    end

    always_comb begin
        n_iq.x = IQ_W'(r_prod[0]) + IQ_W'(r_prod[1]) - IQ_W'(r_prod[2]);
        n_iq.y = IQ_W'(r_prod[3]) + IQ_W'(r_prod[4]) - IQ_W'(r_prod[5]);
        n_iq.z = IQ_W'(r_prod[6]) + IQ_W'(r_prod[7]) - IQ_W'(r_prod[8]);
        n_iq.w = -IQ_W'(r_prod[9]) - IQ_W'(r_prod[10]) - IQ_W'(r_prod[11]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod  <= n_prod;
            r_quat1 <= i_quat;
            r_iq    <= n_iq;
            r_quat2 <= r_quat1;
        end
    end

    assign o_valid = r_v2;
    assign o_iq    = r_iq;
    assign o_quat  = r_quat2;

endmodule

/* hdl/qvr_stage_b.sv */
// (q * v) * conj(q): twelve 33x16 products, then pairwise differences.
module qvr_stage_b
    import qvr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  t_iquat    i_iq,
    input  t_quat     i_quat,
    output logic      o_valid,
    output t_halves   o_halves
);

    logic signed [PROD_W-1:0] n_prod [12];
    logic signed [PROD_W-1:0] r_prod [12];
    t_halves                  n_halves;
    t_halves                  r_halves;
    logic                     r_v1;
    logic                     r_v2;

    // Products ordered as (minuend, subtrahend) pairs.
    always_comb begin
        n_prod[0]  = i_iq.x * i_quat.w;
        n_prod[1]  = i_iq.w * i_quat.x;
        n_prod[2]  = i_iq.z * i_quat.y;
        n_prod[3]  = i_iq.y * i_quat.z;
        n_prod[4]  = i_iq.y * i_quat.w;
        n_prod[5]  = i_iq.w * i_quat.y;
        n_prod[6]  = i_iq.x * i_quat.z;
        n_prod[7]  = i_iq.z * i_quat.x;
        n_prod[8]  = i_iq.z * i_quat.w;
        n_prod[9]  = i_iq.w * i_quat.z;
        n_prod[10] = i_iq.y * i_quat.x;
        n_prod[11] = i_iq.x * i_quat.y;
    end

    always_comb begin
        n_halves.x0 = HALF_W'(r_prod[0])  - HALF_W'(r_prod[1]);
        n_halves.x1 = HALF_W'(r_prod[2])  - HALF_W'(r_prod[3]);
        n_halves.y0 = HALF_W'(r_prod[4])  - HALF_W'(r_prod[5]);
        n_halves.y1 = HALF_W'(r_prod[6])  - HALF_W'(r_prod[7]);
        n_halves.z0 = HALF_W'(r_prod[8])  - HALF_W'(r_prod[9]);
        n_halves.z1 = HALF_W'(r_prod[10]) - HALF_W'(r_prod[11]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod   <= n_prod;
            r_halves <= n_halves;
        end
    end

    assign o_valid  = r_v2;
    assign o_halves = r_halves;

endmodule

/* hdl/qvr_round.sv */
// Final add, round half up, saturate; this is the output register.
module qvr_round
    import qvr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  t_halves   i_halves,
    output logic      o_valid,
    output t_vec      o_rot,
    output logic      o_clip
);

    logic signed [RND_W-1:0] sum_x;
    logic signed [RND_W-1:0] sum_y;
    logic signed [RND_W-1:0] sum_z;
    logic signed [RND_W-1:0] s_x;
    logic signed [RND_W-1:0] s_y;
    logic signed [RND_W-1:0] s_z;
    logic [2:0]              clip_c;
    t_vec                    n_rot;
    t_vec                    r_rot;
    logic                    r_clip;
    logic                    r_valid;

    always_comb begin
        sum_x = RND_W'(i_halves.x0) + RND_W'(i_halves.x1) + RND_HALF;
        sum_y = RND_W'(i_halves.y0) + RND_W'(i_halves.y1) + RND_HALF;
        sum_z = RND_W'(i_halves.z0) + RND_W'(i_halves.z1) + RND_HALF;
        s_x = sum_x >>> RND_SH;
        s_y = sum_y >>> RND_SH;
        s_z = sum_z >>> RND_SH;
    end

    always_comb begin
        clip_c = '0;
        if (s_x > SAT_MAX) begin
            n_rot.x = 16'sh7fff;
            clip_c[0] = 1'b1;
        end else if (s_x < SAT_MIN) begin
            n_rot.x = 16'sh8000;
            clip_c[0] = 1'b1;
        end else begin
            n_rot.x = s_x[COMP_W-1:0];
        end
        if (s_y > SAT_MAX) begin
            n_rot.y = 16'sh7fff;
            clip_c[1] = 1'b1;
        end else if (s_y < SAT_MIN) begin
            n_rot.y = 16'sh8000;
            clip_c[1] = 1'b1;
        end else begin
            n_rot.y = s_y[COMP_W-1:0];
        end
        if (s_z > SAT_MAX) begin
            n_rot.z = 16'sh7fff;
            clip_c[2] = 1'b1;
        end else if (s_z < SAT_MIN) begin
            n_rot.z = 16'sh8000;
            clip_c[2] = 1'b1;
        end else begin
            n_rot.z = s_z[COMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rot  <= n_rot;
            r_clip <= |clip_c;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;
    assign o_clip  = r_clip;

endmodule

/* hdl/quaternion_vector_rotation.sv */
// Throughput: one vector per cycle while the output register is free or being
//   taken; five multiply/add register stages, all advancing together, lie
//   between an accepted input beat and its output beat.
// Reset (i_rst_n low, synchronous): clears all stage valid bits; data
//   registers are not reset.
module quaternion_vector_rotation
    import qvr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] vec_x, [31:16] vec_y, [47:32] vec_z,
    // [63:48] quat_w, [79:64] quat_x, [95:80] quat_y, [111:96] quat_z
    input  logic [111:0] s_axis_tdata,
    // Output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] rot_x, [31:16] rot_y, [47:32] rot_z
    output logic [47:0]  m_axis_tdata,
    // [0] clipped
    output logic [0:0]   m_axis_tuser
);

    t_vec      in_vec;
    t_quat     in_quat;
    t_pipe_ctl ctl_a;
    t_pipe_ctl ctl_b;
    t_pipe_ctl ctl_r;
    logic      pipe_en;

    logic      a_valid;
    t_iquat    a_iq;
    t_quat     a_quat;
    logic      b_valid;
    t_halves   b_halves;
    logic      r_valid;
    t_vec      rot;
    logic      clip;

    // Unpack the input beat.
    assign in_vec.x  = s_axis_tdata[15:0];
    assign in_vec.y  = s_axis_tdata[31:16];
    assign in_vec.z  = s_axis_tdata[47:32];
    assign in_quat.w = s_axis_tdata[63:48];
    assign in_quat.x = s_axis_tdata[79:64];
    assign in_quat.y = s_axis_tdata[95:80];
    assign in_quat.z = s_axis_tdata[111:96];

    // Single global enable: the pipe only freezes when a finished result
    // sits in the output register and the sink is not taking it. Bubbles
    // inside the pipe carry valid=0 and are harmless.
    assign pipe_en       = !r_valid || m_axis_tready;
    assign s_axis_tready = pipe_en;

    assign ctl_a = '{en: pipe_en, valid: s_axis_tvalid};
    assign ctl_b = '{en: pipe_en, valid: a_valid};
    assign ctl_r = '{en: pipe_en, valid: b_valid};

    // Stages 1-2: q * v, exact 33-bit intermediate quaternion.
    qvr_stage_a u_stage_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_a),
        .i_vec   (in_vec),
        .i_quat  (in_quat),
        .o_valid (a_valid),
        .o_iq    (a_iq),
        .o_quat  (a_quat)
    );

    // Stages 3-4: multiply by conj(q), reduce to two terms per component.
    qvr_stage_b u_stage_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_b),
        .i_iq     (a_iq),
        .i_quat   (a_quat),
        .o_valid  (b_valid),
        .o_halves (b_halves)
    );

    // Stage 5: final add, round half up at 2*frac bits, saturate.
    qvr_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_r),
        .i_halves (b_halves),
        .o_valid  (r_valid),
        .o_rot    (rot),
        .o_clip   (clip)
    );

    assign m_axis_tvalid   = r_valid;
    assign m_axis_tdata    = {rot.z, rot.y, rot.x};
    assign m_axis_tuser[0] = clip;

endmodule

/* hdl/qvr_checker.sv */
`include "assert_macros.svh"

module qvr_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [47:0]  m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // A stalled output beat stays offered.
    `QVR_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output beat dropped while stalled")

    // Input is never back-pressured while no output beat is offered.
    `QVR_ASSERT(a_in_ready, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

    // The clip flag implies some component sits at a rail.
    `QVR_ASSERT(a_clip_rail, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[15:0] == 16'h7fff || m_axis_tdata[15:0] == 16'h8000 || m_axis_tdata[31:16] == 16'h7fff || m_axis_tdata[31:16] == 16'h8000 || m_axis_tdata[47:32] == 16'h7fff || m_axis_tdata[47:32] == 16'h8000), "clip set with no saturated component")

    // Reset empties the pipe.
    `QVR_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind quaternion_vector_rotation qvr_checker u_qvr_checker (.*);

/* sim/quaternion_vector_rotation_test.sv */
module quaternion_vector_rotation_test;
    import qvr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no beat on either side before the run is called hung.
    // The longest legal quiet stretch is the output hold-off below.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;      // pipeline is 5 deep
    localparam int IDLE_PCT = 29;
    localparam int HALF_TURN = 11585;      // ~0.7071 in Q2.14

    // One input beat, vec_x in the lowest bits (matches s_axis_tdata).
    typedef struct packed {
        logic signed [COMP_W-1:0] quat_z;
        logic signed [COMP_W-1:0] quat_y;
        logic signed [COMP_W-1:0] quat_x;
        logic signed [COMP_W-1:0] quat_w;
        logic signed [COMP_W-1:0] vec_z;
        logic signed [COMP_W-1:0] vec_y;
        logic signed [COMP_W-1:0] vec_x;
    } t_rot_job;

    // One output beat: {tuser, tdata}.
    typedef struct packed {
        logic                     clipped;
        logic signed [COMP_W-1:0] rot_z;
        logic signed [COMP_W-1:0] rot_y;
        logic signed [COMP_W-1:0] rot_x;
    } t_rot_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [15:0] vec_x, [31:16] vec_y, [47:32] vec_z,
    // [63:48] quat_w, [79:64] quat_x, [95:80] quat_y, [111:96] quat_z
    logic [111:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [15:0] rot_x, [31:16] rot_y, [47:32] rot_z
    logic [47:0]  m_axis_tdata;
    // [0] clipped
    logic [0:0]   m_axis_tuser;

    t_rot_result  pending_rot[$];   // predicted results, oldest first
    int           error_count = 0;
    int           vectors_in = 0;
    int           results_out = 0;
    int           clipped_out = 0;
    int           idle_cycles = 0;
    bit           gaps_on = 1'b1;   // random idling on both sides
    bit           hold_request = 1'b0;
    int           hold_left = 0;

    quaternion_vector_rotation i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Round half up at 2*frac bits, clamp to 16 bits. Returns {clip, value}.
    function automatic logic [COMP_W:0] round_clamp(input longint sum);
        longint q;
        q = (sum + (longint'(1) <<< (2 * QUAT_FRAC_BITS - 1))) >>> (2 * QUAT_FRAC_BITS);
        if (q > 32767) begin
            return {1'b1, 16'h7FFF};
        end
        if (q < -32768) begin
            return {1'b1, 16'h8000};
        end
        return {1'b0, q[COMP_W-1:0]};
    endfunction

    // q * v * conj(q), exact in 64 bits (stage-two sums need 50).
    function automatic t_rot_result rotate_vector(input t_rot_job j);
        longint vx, vy, vz, qw, qx, qy, qz;
        longint ix, iy, iz, iw, sx, sy, sz;
        logic [COMP_W:0] rx, ry, rz;
        t_rot_result r;
        vx = $signed(j.vec_x);
        vy = $signed(j.vec_y);
        vz = $signed(j.vec_z);
        qw = $signed(j.quat_w);
        qx = $signed(j.quat_x);
        qy = $signed(j.quat_y);
        qz = $signed(j.quat_z);
        ix = qw * vx + qy * vz - qz * vy;
        iy = qw * vy + qz * vx - qx * vz;
        iz = qw * vz + qx * vy - qy * vx;
        iw = -(qx * vx) - qy * vy - qz * vz;
        sx = ix * qw - iw * qx - iy * qz + iz * qy;
        sy = iy * qw - iw * qy - iz * qx + ix * qz;
        sz = iz * qw - iw * qz - ix * qy + iy * qx;
        rx = round_clamp(sx);
        ry = round_clamp(sy);
        rz = round_clamp(sz);
        r.rot_x = rx[COMP_W-1:0];
        r.rot_y = ry[COMP_W-1:0];
        r.rot_z = rz[COMP_W-1:0];
        r.clipped = rx[COMP_W] | ry[COMP_W] | rz[COMP_W];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_rot_job make_job(input int vx, input int vy, input int vz,
                                          input int qw, input int qx, input int qy,
                                          input int qz);
        t_rot_job j;
        j.vec_x = 16'(vx);
        j.vec_y = 16'(vy);
        j.vec_z = 16'(vz);
        j.quat_w = 16'(qw);
        j.quat_x = 16'(qx);
        j.quat_y = 16'(qy);
        j.quat_z = 16'(qz);
        return j;
    endfunction

    function automatic int any16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Component of a rotation-like quaternion: |q|^2 stays near or below 2.
    function automatic int turn_part();
        return int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN;
    endfunction

    function automatic int tiny16();
        return int'($urandom_range(0, 200)) - 100;
    endfunction

    // Mostly realistic rotations; some full-range noise that saturates hard.
    function automatic t_rot_job random_job();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return make_job(any16(), any16(), any16(),
                            turn_part(), turn_part(), turn_part(), turn_part());
        end else if (pick < 75) begin
            return make_job(tiny16(), tiny16(), tiny16(),
                            turn_part(), turn_part(), turn_part(), turn_part());
        end
        return make_job(any16(), any16(), any16(), any16(), any16(), any16(), any16());
    endfunction

    // Offer one beat on the input; returns once it has been taken.
    // Called right after an accepting edge, so tvalid sees one update per step.
    task automatic send_vector(input t_rot_job j);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= j;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random tready, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: predict on every input beat, check every output beat.
    // One block so push and pop order within an edge is fixed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rot_result want;
        t_rot_result got;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            pending_rot.push_back(rotate_vector(t_rot_job'(s_axis_tdata)));
            vectors_in++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser[0], m_axis_tdata};
            results_out++;
            if (got.clipped) begin
                clipped_out++;
            end
            if (pending_rot.size() == 0) begin
                $error("unexpected output beat: rot_x %0d rot_y %0d rot_z %0d",
                       got.rot_x, got.rot_y, got.rot_z);
                error_count++;
            end else begin
                want = pending_rot.pop_front();
                if (got.rot_x !== want.rot_x) begin
                    $error("rot_x: expected %0d, got %0d", want.rot_x, got.rot_x);
                    error_count++;
                end
                if (got.rot_y !== want.rot_y) begin
                    $error("rot_y: expected %0d, got %0d", want.rot_y, got.rot_y);
                    error_count++;
                end
                if (got.rot_z !== want.rot_z) begin
                    $error("rot_z: expected %0d, got %0d", want.rot_z, got.rot_z);
                    error_count++;
                end
                if (got.clipped !== want.clipped) begin
                    $error("clipped: expected %0b, got %0b", want.clipped, got.clipped);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: no beat on either side for too long means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d results still pending", pending_rot.size());
            $display("quaternion_vector_rotation_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Full-scale fields, identity, zero, pure axis turns, scale-by-4 overflow.
    task automatic test_field_extremes();
        send_vector(make_job(32767, -32768, 1, 16384, 0, 0, 0));         // identity
        send_vector(make_job(32767, 32767, -32768, 0, 0, 0, 0));         // zero quat
        send_vector(make_job(0, 0, 0, 32767, -32768, 32767, -32768));    // zero vector
        send_vector(make_job(100, -100, 8191, -32768, 0, 0, 0));         // |q|^2 = 4
        send_vector(make_job(8192, -8193, 0, -32768, 0, 0, 0));          // just clips
        send_vector(make_job(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_vector(make_job(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_vector(make_job(1000, 0, 0, HALF_TURN, 0, 0, HALF_TURN));   // 90 deg about z
        send_vector(make_job(1, 2, 3, 0, 16384, 0, 0));                  // 180 deg about x
        send_vector(make_job(-7, 300, -32768, 0, 0, 16384, 0));          // 180 deg about y
        send_vector(make_job(32767, -1, 0, 0, 0, 0, -16384));            // 180 deg about z
        send_vector(make_job(-32768, 32767, -1, 0, 32767, -32768, 0));
        send_vector(make_job(12345, -12345, 32767, 16383, 1, -1, 16383));
        send_vector(make_job(-1, -1, -1, -1, -1, -1, -1));
    endtask

    // qw = 0.5 scales by 1/4: 2 -> 0.5, 6 -> 1.5, ties go toward +infinity.
    task automatic test_rounding_ties();
        send_vector(make_job(2, 6, -6, 8192, 0, 0, 0));
        send_vector(make_job(-2, -6, 6, 8192, 0, 0, 0));
        send_vector(make_job(2, -2, 10, -8192, 0, 0, 0));
        send_vector(make_job(1, -1, 3, 0, 8192, 0, 0));   // quarter-scale, off-tie
        send_vector(make_job(6, -6, 2, 0, 0, 0, -8192));
    endtask

    // First a stretch with no idling anywhere, then idling on both sides.
    task automatic test_random_rotations();
        gaps_on = 1'b0;
        repeat (250) begin
            send_vector(random_job());
        end
        gaps_on = 1'b1;
        repeat (400) begin
            send_vector(random_job());
        end
    endtask

    // Output held off long enough for the pipeline to fill and stall the input.
    task automatic test_output_hold_off();
        hold_request = 1'b1;
        gaps_on = 1'b0;
        repeat (100) begin
            send_vector(random_job());
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_random_mixed();
        repeat (480) begin
            send_vector(random_job());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_rounding_ties();
        test_random_rotations();
        test_output_hold_off();
        test_random_mixed();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_rot.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d vectors rotated, %0d results checked, %0d of them saturated",
                 vectors_in, results_out, clipped_out);
        $display("covered: full-scale fields, rounding ties, axis turns, output hold-off");
        if (error_count == 0) begin
            $display("quaternion_vector_rotation_test OK");
        end else begin
            $display("quaternion_vector_rotation_test NOT OK");
        end
        $finish;
    end

endmodule
